// ----- hw/rtl/integer_to_ascii_formatter_defines.svh -----
// Assertion macros of the integer to ASCII formatter RTL, used by ita_back.
// Users must provide clk_i and rst_ni in the including module's scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define ITAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define ITAF_IMPLIES(lbl, ante, cons, msg) \
  `ITAF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/ita_pkg.sv -----
// Shared types, codes and helper functions of the integer to ASCII formatter.
// No dependencies.
`default_nettype none

package ita_pkg;

  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_UDEC = 3'd1;
  localparam logic [2:0] FUNC_HEXL = 3'd2;
  localparam logic [2:0] FUNC_HEXU = 3'd3;
  localparam logic [2:0] FUNC_PTR  = 3'd4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_LOWA  = 8'd97;
  localparam logic [7:0] ASCII_UPA   = 8'd65;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  localparam logic [3:0] CONV_LAST = 4'd15;

  typedef enum logic {
    KIND_DEC,
    KIND_HEX
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        neg;
    logic        upper;
    logic [63:0] data;
  } job_t;

  function automatic logic [39:0] dabble_bit(logic [39:0] bcd, logic b);
    logic [39:0] adj;
    adj = bcd;
    for (int i = 0; i < 10; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[38:0], b};
  endfunction

  function automatic logic [39:0] dabble2(logic [39:0] bcd, logic [1:0] b);
    return dabble_bit(dabble_bit(bcd, b[1]), b[0]);
  endfunction

  function automatic logic [4:0] lead_count(logic [63:0] d);
    logic [4:0] n;
    n = 5'd1;
    for (int k = 0; k < 16; k++) begin
      if (d[k*4 +: 4] != 4'd0) begin
        n = 5'(k + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] nib_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = ASCII_ZERO + {4'd0, d};
    end else begin
      c = (upper ? ASCII_UPA : ASCII_LOWA) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ita_front.sv -----
// Input side of the formatter: accepts items and classifies them into jobs.
// Depends on ita_pkg.
`default_nettype none

module ita_front import ita_pkg::*; (
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,  // func
  input  wire logic [63:0] s_axis_tdata,  // value
  input  wire logic        full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic        legal;
  logic [31:0] low;

  assign low           = s_axis_tdata[31:0];
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i && legal;

  always_comb begin
    legal = 1'b1;
    job_o = '{kind: KIND_HEX, neg: 1'b0, upper: 1'b0, data: {32'd0, low}};
    unique case (s_axis_tuser)
      FUNC_SDEC: begin
        job_o.kind = KIND_DEC;
        job_o.neg  = low[31];
        job_o.data = {32'd0, (low[31] ? (32'd0 - low) : low)};
      end
      FUNC_UDEC: job_o.kind = KIND_DEC;
      FUNC_HEXL: job_o.kind = KIND_HEX;
      FUNC_HEXU: job_o.upper = 1'b1;
      FUNC_PTR:  job_o.data = s_axis_tdata;
      default:   legal = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ita_queue.sv -----
// Two-entry job queue between the front and back parts of the formatter.
// Depends on ita_pkg.
`default_nettype none

module ita_queue import ita_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      pop_data_o,
  output logic      empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ita_back.sv -----
// Output side of the formatter: converts one job to digits and sends characters.
// Depends on ita_pkg and integer_to_ascii_formatter_defines.svh.
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

module ita_back import ita_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  wire job_t        job_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // char_out[7:0], text_length[12:8], zero pad
  output logic             m_axis_tlast   // last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e      state_q;
  logic [63:0] digs_q;
  logic [31:0] bin_q;
  logic [3:0]  cnt_q, idx_q;
  logic [4:0]  len_q, ndig;
  logic        neg_q, upper_q;
  logic        m_valid_q, m_last_q;
  logic [7:0]  m_char_q;
  logic [4:0]  m_len_q;
  logic        emit_ok;
  logic        emit_go;

  assign emit_ok       = !m_valid_q || m_axis_tready;
  assign emit_go       = ((state_q == S_SIGN) || (state_q == S_EMIT)) && emit_ok;
  assign pop_o         = (state_q == S_IDLE) && !empty_i;
  assign ndig          = lead_count(digs_q);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {3'd0, m_len_q, m_char_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      digs_q    <= '0;
      bin_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      neg_q     <= 1'b0;
      upper_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_char_q  <= '0;
      m_len_q   <= '0;
    end else begin
      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            neg_q   <= job_i.neg;
            upper_q <= job_i.upper;
            if (job_i.kind == KIND_DEC) begin
              bin_q   <= job_i.data[31:0];
              digs_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_CONV;
            end else begin
              digs_q  <= job_i.data;
              state_q <= S_SIZE;
            end
          end
        end
        S_CONV: begin
          digs_q <= {24'd0, dabble2(digs_q[39:0], bin_q[31:30])};
          bin_q  <= {bin_q[29:0], 2'b00};
          cnt_q  <= cnt_q + 4'd1;
          if (cnt_q == CONV_LAST) begin
            state_q <= S_SIZE;
          end
        end
        S_SIZE: begin
          idx_q   <= 4'(ndig - 5'd1);
          len_q   <= ndig + {4'd0, neg_q};
          state_q <= neg_q ? S_SIGN : S_EMIT;
        end
        S_SIGN: begin
          if (emit_ok) begin
            m_char_q  <= ASCII_MINUS;
            m_last_q  <= 1'b0;
            m_len_q   <= '0;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            m_char_q  <= nib_char(digs_q[idx_q*4 +: 4], upper_q);
            m_last_q  <= idx_q == 4'd0;
            m_len_q   <= (idx_q == 4'd0) ? len_q : 5'd0;
            if (idx_q == 4'd0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q - 4'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ITAF_IMPLIES(a_last_len, m_valid_q && m_last_q, m_len_q != 5'd0, "last item without length")
  `ITAF_IMPLIES(a_mid_len, m_valid_q && !m_last_q, m_len_q == 5'd0, "length on a middle item")
  `ITAF_IMPLIES(a_sign_neg, state_q == S_SIGN, neg_q, "sign state on a positive number")
  `ITAF_IMPLIES(a_pop_idle, pop_o, state_q == S_IDLE && !empty_i, "job taken while busy")

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter: an accepted item is queued, taken by the back end in
// S_IDLE, converted in decimal by 16 double-dabble steps at two bits each (S_CONV),
// sized (S_SIZE) and sent at one character per cycle while the output is not stalled.
// An item occupies the back end until its last character is sent, so the two-entry
// queue lets the input run ahead.
// Reset (rst_ni low, asynchronous) empties the queue and idles the output.
`default_nettype none

module integer_to_ascii_formatter import ita_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,  // func
  input  wire logic [63:0] s_axis_tdata,  // value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // char_out[7:0], text_length[12:8], zero pad
  output logic             m_axis_tlast   // last
);

  job_t push_job, pop_job;
  logic push, full, pop, empty;

  ita_front u_front (
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tuser,
    .s_axis_tdata,
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  ita_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  ita_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule

`default_nettype wire
